// ----- design/assert_macros.svh -----
// Assertion macros shared by the line encoder RTL.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/mlenc_pkg.sv -----
// Package for the multi-mode line encoder: mode codes, symbol codes,
// the job record passed from front to back, status structs and a pulse helper.
package mlenc_pkg;

  localparam int SYM_W   = 2;
  localparam int MAX_SYM = 8;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 3;
  localparam int HELD_W  = 3;

  localparam logic [MODE_W-1:0] MODE_NRZL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NRZI   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AMI    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PSEUDO = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MANCH  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DMANCH = 3'd5;
  localparam logic [MODE_W-1:0] MODE_B8ZS   = 3'd6;

  localparam logic [SYM_W-1:0] SYM_ZERO = 2'b00;
  localparam logic [SYM_W-1:0] SYM_POS  = 2'b01;
  localparam logic [SYM_W-1:0] SYM_NEG  = 2'b11;

  localparam logic [HELD_W-1:0] HELD_MAX = 3'd7;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic [MAX_SYM-1:0][SYM_W-1:0] sym;
    logic [IDX_W-1:0]              last_idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } back_stat_t;

  function automatic sym_t pulse_sym(input logic positive);
    pulse_sym = positive ? SYM_POS : SYM_NEG;
  endfunction

endpackage

// ----- design/mlenc_front.sv -----
// Front end of the line encoder: accepts items, keeps polarity and
// held-zero state, and turns each item into a symbol job, except B8ZS zeros that are held. Uses mlenc_pkg.
module mlenc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mlenc_pkg::MODE_W-1:0]  mode,
  input  logic                          clr,
  input  logic                          accept,
  input  logic                          data_bit,
  input  logic                          eos,
  output logic                          job_vld,
  output mlenc_pkg::job_t               job
);
  import mlenc_pkg::*;

  logic              pol_r, pol_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic              p;

  always_comb begin
    pol_nxt  = pol_r;
    held_nxt = held_r;
    job      = '0;
    job_vld  = accept;
    p        = pol_r ^ data_bit;
    case (mode)
      MODE_NRZI: begin
        job.sym[0] = {1'b0, ~p};
        pol_nxt    = p;
      end
      MODE_AMI: begin
        job.sym[0] = data_bit ? pulse_sym(p) : SYM_ZERO;
        pol_nxt    = p;
      end
      MODE_PSEUDO: begin
        job.sym[0] = data_bit ? SYM_ZERO : pulse_sym(~pol_r);
        pol_nxt    = pol_r ^ ~data_bit;
      end
      MODE_MANCH: begin
        job.sym[0]    = {1'b0, ~data_bit};
        job.sym[1]    = {1'b0, data_bit};
        job.last_idx  = IDX_W'(1);
      end
      MODE_DMANCH: begin
        job.sym[0]    = {1'b0, p};
        job.sym[1]    = {1'b0, ~p};
        job.last_idx  = IDX_W'(1);
        pol_nxt       = p;
      end
      MODE_B8ZS: begin
        if (data_bit) begin
          job.sym[held_r] = pulse_sym(~pol_r);
          job.last_idx    = held_r;
          held_nxt        = '0;
          pol_nxt         = ~pol_r;
        end else if (held_r == HELD_MAX) begin
          job.sym[3]   = pulse_sym(pol_r);
          job.sym[4]   = pulse_sym(~pol_r);
          job.sym[6]   = pulse_sym(~pol_r);
          job.sym[7]   = pulse_sym(pol_r);
          job.last_idx = IDX_W'(MAX_SYM - 1);
          held_nxt     = '0;
        end else if (eos) begin
          job.last_idx = held_r;
          held_nxt     = '0;
        end else begin
          job_vld  = 1'b0;
          held_nxt = held_r + HELD_W'(1);
        end
      end
      default: begin
        job.sym[0] = {1'b0, data_bit};
      end
    endcase
    if (eos) begin
      pol_nxt  = 1'b0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pol_r  <= 1'b0;
      held_r <= '0;
    end else if (accept) begin
      pol_r  <= pol_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ----- design/mlenc_fifo.sv -----
// Short job queue between front and back of the line encoder.
// Register storage, one write and one read port. Uses mlenc_pkg.
module mlenc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  enq,
  input  mlenc_pkg::job_t       enq_data,
  input  logic                  deq,
  output mlenc_pkg::job_t       deq_data,
  output mlenc_pkg::fifo_stat_t stat
);
  import mlenc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign deq_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= enq_data;
    end
  end

endmodule

// ----- design/mlenc_back.sv -----
// Back end of the line encoder: walks each job one symbol per cycle into
// the result register while it is free or popped. Uses mlenc_pkg.
module mlenc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_avail,
  input  mlenc_pkg::job_t       job,
  output logic                  job_take,
  input  logic                  pop,
  output logic                  out_vld,
  output mlenc_pkg::sym_t       out_sym,
  output logic                  out_last,
  output mlenc_pkg::back_stat_t stat
);
  import mlenc_pkg::*;

  job_t             cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r, busy_nxt;
  logic             out_vld_r;
  sym_t             out_sym_r;
  logic             out_last_r;
  logic             load_out;
  logic             at_last;
  logic             finish;

  assign load_out = busy_r && (!out_vld_r || pop);
  assign at_last  = (idx_r == cur_r.last_idx);
  assign finish   = load_out && at_last;
  assign job_take = job_avail && (!busy_r || finish);
  assign busy_nxt = job_take ? 1'b1 : (finish ? 1'b0 : busy_r);

  assign out_vld     = out_vld_r;
  assign out_sym     = out_sym_r;
  assign out_last    = out_last_r;
  assign stat.busy   = busy_r;
  assign stat.finish = finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      if (job_take) begin
        idx_r <= '0;
      end else if (load_out) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_r <= job;
    end
    if (load_out) begin
      out_sym_r  <= cur_r.sym[idx_r];
      out_last_r <= at_last;
    end
  end

endmodule

// ----- design/multi_mode_line_encoder_top.sv -----
// Channel   Handshake            Payload
// input     push / full          in_data_bit, in_end_of_stream
// result    pop / empty          out_line_symbol, out_run_last
// config    cfg_we               cfg_wdata (code_mode)
//
// The front takes one item per cycle while the job queue has room; the back
// emits one symbol per cycle while its result is free or popped; an item
// makes 1 symbol, 2 in Manchester modes, up to 8 in B8ZS. Reset
// (synchronous, rst_n low) resets the encoder state; a config write clears
// only the front's polarity and held-zero state. Pop low stalls the back,
// which stalls the queue and then the front through full.
`include "assert_macros.svh"

module multi_mode_line_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_data_bit,
  input  logic                         in_end_of_stream,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [1:0]            out_line_symbol,
  output logic                         out_run_last,
  input  logic                         cfg_we,
  input  logic [mlenc_pkg::MODE_W-1:0] cfg_wdata
);
  import mlenc_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              accept;
  logic              q_enq;
  logic              q_deq;
  job_t              fr_job;
  job_t              q_job;
  fifo_stat_t        q_stat;
  back_stat_t        bk_stat;
  logic              out_vld;
  sym_t              out_sym;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NRZL;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  mlenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .clr      (cfg_we),
    .accept   (accept),
    .data_bit (in_data_bit),
    .eos      (in_end_of_stream),
    .job_vld  (q_enq),
    .job      (fr_job)
  );

  mlenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .enq      (q_enq),
    .enq_data (fr_job),
    .deq      (q_deq),
    .deq_data (q_job),
    .stat     (q_stat)
  );

  mlenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_stat.empty),
    .job       (q_job),
    .job_take  (q_deq),
    .pop       (pop && out_vld),
    .out_vld   (out_vld),
    .out_sym   (out_sym),
    .out_last  (out_run_last),
    .stat      (bk_stat)
  );

  assign empty           = !out_vld;
  assign out_line_symbol = out_sym;

  `ASSERT_NEVER(a_queue_overflow, q_enq && q_stat.full, "job queue overflow")
  `ASSERT_NEVER(a_queue_underflow, q_deq && q_stat.empty, "job queue underflow")
  `ASSERT_CLK(a_take_when_free, q_deq |-> (!bk_stat.busy || bk_stat.finish), "job taken while busy")
  `ASSERT_CLK(a_finish_loads, bk_stat.finish |=> !empty, "finished job left no result")

endmodule
